[design/ffsa_pkg.sv]
// Shared constants and types for the first-fit segment allocator.
package ffsa_pkg;

   localparam int MAX_SEGMENTS_DEF = 64;
   localparam int OWNER_BITS_DEF   = 8;

   localparam int SZ_W       = 17;
   localparam int STATUS_W   = 2;
   localparam int ADDR_OUT_W = 16;
   localparam int USED_OUT_W = 7;
   localparam int OWNER_IN_W = 8;
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;

   localparam logic [SZ_W-1:0] MEM_LIMIT = 17'd65536;
   localparam logic [SZ_W-1:0] TOTAL_RST = 17'd16384;
   localparam logic [SZ_W-1:0] PSIZE_RST = 17'd4096;

   localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOOWNER = 2'd3;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic REG_TOTAL = 1'b0;
   localparam logic REG_PSIZE = 1'b1;

   typedef struct packed {
      logic            reinit;
      logic [SZ_W-1:0] init_total;
      logic [SZ_W-1:0] process_size;
   } cfg_type;

   typedef struct packed {
      logic                  valid;
      logic [STATUS_W-1:0]   status;
      logic [ADDR_OUT_W-1:0] start_address;
      logic [USED_OUT_W-1:0] used_segments;
      logic [SZ_W-1:0]       free_total;
   } rsp_type;

endpackage

[design/ffsa_seg_ram.sv]
// Segment table storage: one write port, one registered read port.
module ffsa_seg_ram #(
   parameter int DEPTH = ffsa_pkg::MAX_SEGMENTS_DEF,
   parameter int WIDTH = 2 * ffsa_pkg::SZ_W + 1 + ffsa_pkg::OWNER_BITS_DEF,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/ffsa_ctrl.sv]
// Request sequencer: table scan, insert and erase shifts, running totals.
module ffsa_ctrl #(
   parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF,
   parameter int OWNER_BITS   = ffsa_pkg::OWNER_BITS_DEF,
   localparam int AW = $clog2(MAX_SEGMENTS),
   localparam int EW = 2 * ffsa_pkg::SZ_W + 1 + OWNER_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              func,
   input  logic [ffsa_pkg::OWNER_IN_W-1:0]   owner_id,
   output logic                              busy,
   input  ffsa_pkg::cfg_type                 cfg,
   output ffsa_pkg::rsp_type                 rsp,
   output logic                              ram_wr_en,
   output logic [AW-1:0]                     ram_wr_addr,
   output logic [EW-1:0]                     ram_wr_data,
   output logic                              ram_rd_en,
   output logic [AW-1:0]                     ram_rd_addr,
   input  logic [EW-1:0]                     ram_rd_data
);
   import ffsa_pkg::*;

   localparam int CW  = $clog2(MAX_SEGMENTS + 1);
   localparam int OB  = OWNER_BITS;
   localparam int OXW = (OB > OWNER_IN_W) ? OB : OWNER_IN_W;
   localparam int UW  = (CW > USED_OUT_W) ? CW : USED_OUT_W;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_ASHIFT = 3'd2;
   localparam logic [2:0] S_AFIN   = 3'd3;
   localparam logic [2:0] S_FNEXT  = 3'd4;
   localparam logic [2:0] S_ESHIFT = 3'd5;
   localparam logic [2:0] S_RESP   = 3'd6;

   function automatic logic [EW-1:0] pack_entry(input logic [SZ_W-1:0] s,
                                                input logic [SZ_W-1:0] z,
                                                input logic            u,
                                                input logic [OB-1:0]   o);
      return {s, z, u, o};
   endfunction

   logic [2:0]          state_ff, state_in;
   logic                func_ff, func_in;
   logic [OB-1:0]       owner_ff, owner_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [CW-1:0]       hit_ff, hit_in;
   logic [CW-1:0]       ptr_ff, ptr_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [UW-1:0]       used_ff, used_in;
   logic [SZ_W-1:0]     free_ff, free_in;
   logic [SZ_W-1:0]     base_ff, base_in;
   logic                fresh_ff, fresh_in;
   logic                rd_fresh_ff, rd_fresh_in;
   logic [SZ_W-1:0]     prev_start_ff, prev_start_in;
   logic [SZ_W-1:0]     prev_size_ff, prev_size_in;
   logic                prev_used_ff, prev_used_in;
   logic [SZ_W-1:0]     hit_start_ff, hit_start_in;
   logic [SZ_W-1:0]     hit_size_ff, hit_size_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [SZ_W-1:0]     addr_ff, addr_in;

   logic [OXW-1:0]  owner_ext;
   logic [OB-1:0]   owner_req;
   logic [EW-1:0]   ent;
   logic [SZ_W-1:0] cur_start, cur_size;
   logic            cur_used;
   logic [OB-1:0]   cur_owner;
   logic [CW-1:0]   idx_p1, cnt_m1, hit_p1, hit_p2, ptr_p1, ptr_p2, ptr_m1;
   logic [SZ_W-1:0] psize;

   assign owner_ext = OXW'(owner_id);
   assign owner_req = owner_ext[OB-1:0];
   assign psize     = cfg.process_size;

   // entry 0 reads as the initial whole-memory segment until first written
   assign ent = rd_fresh_ff ? pack_entry('0, base_ff, 1'b0, '0) : ram_rd_data;
   assign cur_start = ent[EW-1 -: SZ_W];
   assign cur_size  = ent[EW-1-SZ_W -: SZ_W];
   assign cur_used  = ent[OB];
   assign cur_owner = ent[OB-1:0];

   assign idx_p1 = idx_ff + CW'(1);
   assign cnt_m1 = cnt_ff - CW'(1);
   assign hit_p1 = hit_ff + CW'(1);
   assign hit_p2 = hit_ff + CW'(2);
   assign ptr_p1 = ptr_ff + CW'(1);
   assign ptr_p2 = ptr_ff + CW'(2);
   assign ptr_m1 = ptr_ff - CW'(1);

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      owner_in      = owner_ff;
      idx_in        = idx_ff;
      hit_in        = hit_ff;
      ptr_in        = ptr_ff;
      cnt_in        = cnt_ff;
      used_in       = used_ff;
      free_in       = free_ff;
      base_in       = base_ff;
      prev_start_in = prev_start_ff;
      prev_size_in  = prev_size_ff;
      prev_used_in  = prev_used_ff;
      hit_start_in  = hit_start_ff;
      hit_size_in   = hit_size_ff;
      status_in     = status_ff;
      addr_in       = addr_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = '0;
      ram_wr_data   = '0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               func_in     = func;
               owner_in    = owner_req;
               idx_in      = '0;
               ram_rd_en   = 1'b1;
               ram_rd_addr = '0;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            // read of the following entry is in flight unless an insert shift begins
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx_p1[AW-1:0];
            if (idx_ff >= cnt_ff) begin
               status_in = (func_ff == FUNC_FREE) ? ST_NOOWNER : ST_NOFIT;
               addr_in   = '0;
               state_in  = S_RESP;
            end else if (func_ff == FUNC_ALLOC && !cur_used && cur_size >= psize) begin
               hit_in       = idx_ff;
               hit_start_in = cur_start;
               hit_size_in  = cur_size;
               if (cur_size != psize && cnt_ff >= CW'(MAX_SEGMENTS)) begin
                  status_in = ST_FULL;
                  addr_in   = '0;
                  state_in  = S_RESP;
               end else begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = idx_ff[AW-1:0];
                  ram_wr_data = pack_entry(cur_start, psize, 1'b1, owner_ff);
                  status_in   = ST_DONE;
                  addr_in     = cur_start;
                  used_in     = used_ff + UW'(1);
                  free_in     = free_ff - psize;
                  if (cur_size == psize) begin
                     state_in = S_RESP;
                  end else if (cnt_m1 == idx_ff) begin
                     state_in = S_AFIN;
                  end else begin
                     // open the gap from the top entry downward
                     ram_rd_addr = cnt_m1[AW-1:0];
                     ptr_in      = cnt_m1;
                     state_in    = S_ASHIFT;
                  end
               end
            end else if (func_ff == FUNC_FREE && cur_used && cur_owner == owner_ff) begin
               hit_in       = idx_ff;
               hit_start_in = cur_start;
               hit_size_in  = cur_size;
               status_in    = ST_DONE;
               addr_in      = cur_start;
               used_in      = used_ff - UW'(1);
               free_in      = free_ff + cur_size;
               if (idx_ff != '0 && !prev_used_ff) begin
                  // fold into the free predecessor, then erase this entry
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = AW'(idx_ff - CW'(1));
                  ram_wr_data = pack_entry(prev_start_ff, prev_size_ff + cur_size, 1'b0, '0);
                  if (idx_p1 < cnt_ff) begin
                     ptr_in   = idx_ff;
                     state_in = S_ESHIFT;
                  end else begin
                     cnt_in   = cnt_m1;
                     state_in = S_RESP;
                  end
               end else if (idx_p1 < cnt_ff) begin
                  state_in = S_FNEXT;
               end else begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = idx_ff[AW-1:0];
                  ram_wr_data = pack_entry(cur_start, cur_size, 1'b0, '0);
                  state_in    = S_RESP;
               end
            end else begin
               prev_start_in = cur_start;
               prev_size_in  = cur_size;
               prev_used_in  = cur_used;
               idx_in        = idx_p1;
            end
         end
         S_ASHIFT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = AW'(ptr_p1);
            ram_wr_data = ent;
            if (ptr_ff == hit_p1) begin
               state_in = S_AFIN;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = ptr_m1[AW-1:0];
               ptr_in      = ptr_m1;
            end
         end
         S_AFIN: begin
            // remainder of the split goes right after the granted segment
            ram_wr_en   = 1'b1;
            ram_wr_addr = hit_p1[AW-1:0];
            ram_wr_data = pack_entry(hit_start_ff + psize, hit_size_ff - psize, 1'b0, '0);
            cnt_in      = cnt_ff + CW'(1);
            state_in    = S_RESP;
         end
         S_FNEXT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = hit_ff[AW-1:0];
            if (!cur_used) begin
               ram_wr_data = pack_entry(hit_start_ff, hit_size_ff + cur_size, 1'b0, '0);
               if (hit_p2 < cnt_ff) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = hit_p2[AW-1:0];
                  ptr_in      = hit_p1;
                  state_in    = S_ESHIFT;
               end else begin
                  cnt_in   = cnt_m1;
                  state_in = S_RESP;
               end
            end else begin
               ram_wr_data = pack_entry(hit_start_ff, hit_size_ff, 1'b0, '0);
               state_in    = S_RESP;
            end
         end
         S_ESHIFT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = ptr_ff[AW-1:0];
            ram_wr_data = ent;
            if (ptr_p1 == cnt_m1) begin
               cnt_in   = cnt_m1;
               state_in = S_RESP;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = ptr_p2[AW-1:0];
               ptr_in      = ptr_p1;
            end
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      fresh_in = fresh_ff && !(ram_wr_en && ram_wr_addr == '0);
      rd_fresh_in = ram_rd_en && ram_rd_addr == '0 && fresh_ff;

      if (cfg.reinit) begin
         cnt_in   = CW'(1);
         used_in  = '0;
         free_in  = cfg.init_total;
         base_in  = cfg.init_total;
         fresh_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         cnt_ff      <= CW'(1);
         used_ff     <= '0;
         free_ff     <= TOTAL_RST;
         base_ff     <= TOTAL_RST;
         fresh_ff    <= 1'b1;
         rd_fresh_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         used_ff     <= used_in;
         free_ff     <= free_in;
         base_ff     <= base_in;
         fresh_ff    <= fresh_in;
         rd_fresh_ff <= rd_fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      owner_ff      <= owner_in;
      idx_ff        <= idx_in;
      hit_ff        <= hit_in;
      ptr_ff        <= ptr_in;
      prev_start_ff <= prev_start_in;
      prev_size_ff  <= prev_size_in;
      prev_used_ff  <= prev_used_in;
      hit_start_ff  <= hit_start_in;
      hit_size_ff   <= hit_size_in;
      status_ff     <= status_in;
      addr_ff       <= addr_in;
   end

   assign busy = (state_ff != S_IDLE);

   assign rsp.valid         = (state_ff == S_RESP);
   assign rsp.status        = status_ff;
   assign rsp.start_address = addr_ff[ADDR_OUT_W-1:0];
   assign rsp.used_segments = used_ff[USED_OUT_W-1:0];
   assign rsp.free_total    = free_ff;

endmodule

[design/first_fit_segment_allocator.sv]
// Top level: first-fit segment allocator with CSR block and segment table RAM.
// Each item scans entries in order (up to the hit, or the whole table on a miss), moves
//   entries for an insert or erase, then writes a split remainder or checks the successor.
// busy drops the cycle after the result; a new item is taken only once busy is low, and
//   every scan goes through the single RAM read port.
// Reset (synchronous): one free segment [0, 16384), process_size 4096; receiver cannot stall.
module first_fit_segment_allocator #(
   parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF,
   parameter int OWNER_BITS   = ffsa_pkg::OWNER_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_func,
   input  logic [ffsa_pkg::OWNER_IN_W-1:0]   req_owner_id,
   // result channel
   output logic                              rsp_valid,
   output logic [ffsa_pkg::STATUS_W-1:0]     rsp_status,
   output logic [ffsa_pkg::ADDR_OUT_W-1:0]   rsp_start_address,
   output logic [ffsa_pkg::USED_OUT_W-1:0]   rsp_used_segments,
   output logic [ffsa_pkg::SZ_W-1:0]         rsp_free_total,
   // register port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ffsa_pkg::CSR_AW-1:0]       paddr,
   input  logic [ffsa_pkg::CSR_DW-1:0]       pwdata,
   output logic [ffsa_pkg::CSR_DW-1:0]       prdata,
   output logic                              pready
);
   import ffsa_pkg::*;

   localparam int AW = $clog2(MAX_SEGMENTS);
   localparam int EW = 2 * SZ_W + 1 + OWNER_BITS;

   // ---------------------------------------------------------------
   // Registers. Writing total_memory saturates at 64K and restarts the
   // table as one free segment; process_size applies to later items.
   // ---------------------------------------------------------------
   logic [SZ_W-1:0] total_ff, total_in;
   logic [SZ_W-1:0] psize_ff, psize_in;
   logic            csr_wr;
   logic            csr_sel;
   logic [SZ_W-1:0] csr_wval;
   logic [SZ_W-1:0] csr_total_sat;

   assign pready        = 1'b1;
   assign csr_wr        = psel && penable && pwrite && pready;
   assign csr_sel       = paddr[2];
   assign csr_wval      = pwdata[SZ_W-1:0];
   assign csr_total_sat = (csr_wval > MEM_LIMIT) ? MEM_LIMIT : csr_wval;

   always_comb begin
      total_in = total_ff;
      psize_in = psize_ff;
      if (csr_wr) begin
         case (csr_sel)
            REG_TOTAL: total_in = csr_total_sat;
            REG_PSIZE: psize_in = csr_wval;
            default:   total_in = total_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= TOTAL_RST;
         psize_ff <= PSIZE_RST;
      end else begin
         total_ff <= total_in;
         psize_ff <= psize_in;
      end
   end

   always_comb begin
      case (csr_sel)
         REG_TOTAL: prdata = CSR_DW'(total_ff);
         REG_PSIZE: prdata = CSR_DW'(psize_ff);
         default:   prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // Sequencer and table RAM
   // ---------------------------------------------------------------
   cfg_type          cfg;
   rsp_type          rsp;
   logic             ram_wr_en;
   logic [AW-1:0]    ram_wr_addr;
   logic [EW-1:0]    ram_wr_data;
   logic             ram_rd_en;
   logic [AW-1:0]    ram_rd_addr;
   logic [EW-1:0]    ram_rd_data;

   assign cfg.reinit       = csr_wr && (csr_sel == REG_TOTAL);
   assign cfg.init_total   = csr_total_sat;
   assign cfg.process_size = psize_ff;

   ffsa_ctrl #(
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .OWNER_BITS   (OWNER_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .func        (req_func),
      .owner_id    (req_owner_id),
      .busy        (busy),
      .cfg         (cfg),
      .rsp         (rsp),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   ffsa_seg_ram #(
      .DEPTH (MAX_SEGMENTS),
      .WIDTH (EW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid         = rsp.valid;
   assign rsp_status        = rsp.status;
   assign rsp_start_address = rsp.start_address;
   assign rsp_used_segments = rsp.used_segments;
   assign rsp_free_total    = rsp.free_total;

`ifndef ASSERT_OFF
   // an accepted item keeps the block busy through its work
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   // the result strobe is a single-cycle pulse and ends the item
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("result strobe longer than one cycle");

   // failed items report address zero
   a_fail_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_DONE |-> rsp_start_address == '0)
      else $error("failed item reported a nonzero address");

   // free space never exceeds the managed size
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_free_total <= MEM_LIMIT)
      else $error("free total above memory limit");
`endif

endmodule

[tb/first_fit_segment_allocator_test.sv]
// Self-checking testbench for the first-fit segment allocator: directed table, random episodes.
module first_fit_segment_allocator_test;
   import ffsa_pkg::*;

   localparam int SEGS         = MAX_SEGMENTS_DEF;
   localparam int RANDOM_ITEMS = 950;
   // Slowest item: a scan of the whole table. The longest sender gap is capped at
   // GAP_MAX. A total_memory write takes effect at once.
   // Any quiet stretch far beyond that means the block has hung.
   localparam int STALL_MAX    = 4000;
   localparam int DRAIN_WAIT   = 2*SEGS + 12;
   localparam int GAP_MAX      = 60;
   localparam logic [SZ_W-1:0] SZ_ALL_ONES = 17'h1FFFF;

   // One result as the block reports it.
   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [ADDR_OUT_W-1:0] addr;
      logic [USED_OUT_W-1:0] used;
      logic [SZ_W-1:0]       free_sz;
   } outcome_type;

   // Directed table row: either a request or a register write.
   typedef struct {
      logic                  is_csr;
      logic                  reg_sel;
      logic [SZ_W-1:0]       value;
      logic                  func;
      logic [OWNER_IN_W-1:0] owner;
      logic                  typed;     // want holds a hand-written expectation
      outcome_type           want;
   } stim_row_type;

   // ---------------------------------------------------------------------------
   // DUT hookup; every input starts at a known value
   // ---------------------------------------------------------------------------
   logic                  clock        = 1'b0;
   logic                  reset        = 1'b1;
   logic                  start        = 1'b0;
   logic                  req_func     = FUNC_ALLOC;
   logic [OWNER_IN_W-1:0] req_owner_id = '0;
   logic                  psel         = 1'b0;
   logic                  penable      = 1'b0;
   logic                  pwrite       = 1'b0;
   logic [CSR_AW-1:0]     paddr        = '0;
   logic [CSR_DW-1:0]     pwdata       = '0;
   logic                  busy;
   logic                  rsp_valid;
   logic [STATUS_W-1:0]   rsp_status;
   logic [ADDR_OUT_W-1:0] rsp_start_address;
   logic [USED_OUT_W-1:0] rsp_used_segments;
   logic [SZ_W-1:0]       rsp_free_total;
   logic [CSR_DW-1:0]     prdata;
   logic                  pready;

   always #5 clock = ~clock;

   first_fit_segment_allocator u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_owner_id      (req_owner_id),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_start_address (rsp_start_address),
      .rsp_used_segments (rsp_used_segments),
      .rsp_free_total    (rsp_free_total),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   // ---------------------------------------------------------------------------
   // Segment table shadow: address-ordered entries, same layout as the block
   // ---------------------------------------------------------------------------
   logic [SZ_W-1:0]       blk_start [SEGS];
   logic [SZ_W-1:0]       blk_size  [SEGS];
   logic                  blk_held  [SEGS];
   logic [OWNER_IN_W-1:0] blk_owner [SEGS];
   int                    blk_count;
   logic [SZ_W-1:0]       memory_size;
   logic [SZ_W-1:0]       grant_size;

   outcome_type  pending_outcomes [$];   // one per accepted item, oldest first
   stim_row_type directed_rows [$];

   int n_errors = 0;
   int n_items  = 0;
   int n_csr    = 0;
   int status_seen [4] = '{0, 0, 0, 0};
   int sender_idle_pct = 31;

   // whole memory becomes one free segment
   function automatic void table_reinit();
      int k;
      for (k = 0; k < SEGS; k++) begin
         blk_start[k] = '0;
         blk_size[k]  = '0;
         blk_held[k]  = 1'b0;
         blk_owner[k] = '0;
      end
      blk_size[0] = memory_size;
      blk_count   = 1;
   endfunction

   function automatic void copy_entry(int dst, int src);
      blk_start[dst] = blk_start[src];
      blk_size[dst]  = blk_size[src];
      blk_held[dst]  = blk_held[src];
      blk_owner[dst] = blk_owner[src];
   endfunction

   // shift entries pos.. up by one to make room
   function automatic void open_slot(int pos);
      int k;
      for (k = blk_count; k > pos; k--)
         copy_entry(k, k - 1);
      blk_count++;
   endfunction

   // drop entry pos, shift the rest down, clear the vacated top entry
   function automatic void close_slot(int pos);
      int k;
      for (k = pos; k + 1 < blk_count; k++)
         copy_entry(k, k + 1);
      blk_count--;
      blk_start[blk_count] = '0;
      blk_size[blk_count]  = '0;
      blk_held[blk_count]  = 1'b0;
      blk_owner[blk_count] = '0;
   endfunction

   // Applies one request to the shadow table and returns what the block should report.
   function automatic outcome_type table_apply_request(logic func,
                                                       logic [OWNER_IN_W-1:0] owner);
      outcome_type res;
      int          i;
      int          hit;
      int          used_n;
      int          free_sum;
      res        = '0;
      res.status = (func == FUNC_ALLOC) ? ST_NOFIT : ST_NOOWNER;
      hit        = -1;
      // first fit for allocate, lowest-addressed holding for free
      for (i = 0; i < blk_count && hit < 0; i++) begin
         if (func == FUNC_ALLOC) begin
            if (!blk_held[i] && blk_size[i] >= grant_size) hit = i;
         end else begin
            if (blk_held[i] && blk_owner[i] == owner) hit = i;
         end
      end
      if (hit >= 0 && func == FUNC_ALLOC) begin
         if (blk_size[hit] != grant_size && blk_count >= SEGS) begin
            res.status = ST_FULL;     // split needed but no room; table untouched
         end else begin
            if (blk_size[hit] != grant_size) begin
               open_slot(hit + 1);
               blk_start[hit+1] = blk_start[hit] + grant_size;
               blk_size[hit+1]  = blk_size[hit] - grant_size;
               blk_held[hit+1]  = 1'b0;
               blk_owner[hit+1] = '0;
               blk_size[hit]    = grant_size;
            end
            blk_held[hit]  = 1'b1;
            blk_owner[hit] = owner;
            res.status     = ST_DONE;
            res.addr       = blk_start[hit][ADDR_OUT_W-1:0];
         end
      end else if (hit >= 0) begin
         res.status     = ST_DONE;
         res.addr       = blk_start[hit][ADDR_OUT_W-1:0];
         blk_held[hit]  = 1'b0;
         blk_owner[hit] = '0;
         // merge into free predecessor, else absorb free successor, never both
         if (hit > 0 && !blk_held[hit-1]) begin
            blk_size[hit-1] = blk_size[hit-1] + blk_size[hit];
            close_slot(hit);
         end else if (hit + 1 < blk_count && !blk_held[hit+1]) begin
            blk_size[hit] = blk_size[hit] + blk_size[hit+1];
            close_slot(hit + 1);
         end
      end
      used_n   = 0;
      free_sum = 0;
      for (i = 0; i < blk_count; i++) begin
         if (blk_held[i]) used_n++;
         else free_sum += blk_size[i];
      end
      res.used    = used_n[USED_OUT_W-1:0];
      res.free_sz = free_sum[SZ_W-1:0];
      return res;
   endfunction

   // ---------------------------------------------------------------------------
   // Directed table helpers
   // ---------------------------------------------------------------------------
   function automatic void item_row(logic func, logic [OWNER_IN_W-1:0] owner,
                                    logic [STATUS_W-1:0] status, logic [ADDR_OUT_W-1:0] addr,
                                    logic [USED_OUT_W-1:0] used, logic [SZ_W-1:0] free_sz);
      stim_row_type r;
      r        = '{default: '0};
      r.func   = func;
      r.owner  = owner;
      r.typed  = 1'b1;
      r.want   = {status, addr, used, free_sz};
      directed_rows = {directed_rows, r};
   endfunction

   // row whose expectation comes from the shadow table
   function automatic void item_pred(logic func, logic [OWNER_IN_W-1:0] owner);
      stim_row_type r;
      r       = '{default: '0};
      r.func  = func;
      r.owner = owner;
      directed_rows = {directed_rows, r};
   endfunction

   function automatic void csr_row(logic reg_sel, logic [SZ_W-1:0] value);
      stim_row_type r;
      r         = '{default: '0};
      r.is_csr  = 1'b1;
      r.reg_sel = reg_sel;
      r.value   = value;
      directed_rows = {directed_rows, r};
   endfunction

   // ---------------------------------------------------------------------------
   // Drivers: inputs change on the falling edge, handshakes sampled on the rising edge
   // ---------------------------------------------------------------------------

   // Setup + access phase; register takes the value at the edge with penable high.
   task automatic csr_write(input logic reg_sel, input logic [SZ_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_sel, 2'b00};
      pwdata  <= CSR_DW'(value);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (reg_sel == REG_TOTAL) begin
         memory_size = (value > MEM_LIMIT) ? MEM_LIMIT : value;   // saturates
         table_reinit();
      end else begin
         grant_size = value;
      end
      n_csr++;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Drop start, then wait until every outstanding result is back and busy is low.
   // Every item yields exactly one result, so no extra settling time is needed.
   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      @(negedge clock);
      while (busy) @(negedge clock);
   endtask

   // Present one item, with a random gap in front; occasionally hold off until drained.
   // start stays high after acceptance: busy covers the next cycles, and the next call
   // either lowers it or puts the next item on the bus.
   task automatic send_request(input logic func, input logic [OWNER_IN_W-1:0] owner,
                               input logic typed, input outcome_type want);
      int          gap;
      logic        hold;
      outcome_type got;
      gap = 0;
      while (gap < GAP_MAX && $urandom_range(99) < sender_idle_pct) gap++;
      hold = ($urandom_range(63) == 0);
      @(negedge clock);
      if (gap > 0 || hold) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
         if (hold) begin
            while (pending_outcomes.size() != 0) @(posedge clock);
            @(negedge clock);
         end
      end
      start        <= 1'b1;
      req_func     <= func;
      req_owner_id <= owner;
      @(posedge clock);
      while (busy) @(posedge clock);
      // accepted at this edge
      got = table_apply_request(func, owner);
      if (typed) got = want;
      pending_outcomes = {pending_outcomes, got};
      n_items++;
   endtask

   // ---------------------------------------------------------------------------
   // Result checker: each strobe is matched against the oldest expectation
   // ---------------------------------------------------------------------------
   outcome_type head;

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
         n_errors++;
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, seen);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_outcomes.size() == 0) begin
            n_errors++;
            $display("%0t: result with nothing outstanding: expected none, got status %0d",
                     $time, rsp_status);
         end else begin
            head = pending_outcomes[0];
            pending_outcomes.delete(0);
            check_field("status",        32'(head.status),  32'(rsp_status));
            check_field("start_address", 32'(head.addr),    32'(rsp_start_address));
            check_field("used_segments", 32'(head.used),    32'(rsp_used_segments));
            check_field("free_total",    32'(head.free_sz), 32'(rsp_free_total));
            status_seen[head.status]++;
         end
      end
   end

   // Watchdog: any item, result or register access counts as progress.
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid === 1'b1 || (psel && penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_MAX) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_MAX);
         $display("first_fit_segment_allocator test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------
   initial begin
      logic                  fill;
      logic                  func;
      logic [OWNER_IN_W-1:0] owner;
      logic [OWNER_IN_W-1:0] pool [6];
      logic [SZ_W-1:0]       mem;
      logic [SZ_W-1:0]       psz;
      int                    pool_n;
      int                    len;
      int                    alloc_pct;
      int                    k;
      int                    n_random;
      int                    n_directed;

      memory_size = TOTAL_RST;
      grant_size  = PSIZE_RST;
      table_reinit();

      // Reset defaults: 16 KiB in four 4 KiB grants.
      item_row (FUNC_ALLOC, 8'h00, ST_DONE,    16'd0,     7'd1, 17'd12288);
      item_row (FUNC_ALLOC, 8'hFF, ST_DONE,    16'd4096,  7'd2, 17'd8192);
      item_pred(FUNC_ALLOC, 8'hAA);
      item_row (FUNC_ALLOC, 8'h55, ST_DONE,    16'd12288, 7'd4, 17'd0);   // exact fit
      item_row (FUNC_ALLOC, 8'h01, ST_NOFIT,   16'd0,     7'd4, 17'd0);
      item_row (FUNC_FREE,  8'h07, ST_NOOWNER, 16'd0,     7'd4, 17'd0);
      // frees: no free neighbor, absorb successor, last entry, merge into predecessor
      // while a free successor stays separate
      item_pred(FUNC_FREE,  8'hFF);
      item_pred(FUNC_FREE,  8'h00);
      item_pred(FUNC_FREE,  8'h55);
      item_pred(FUNC_FREE,  8'hAA);
      // one owner holding two segments; free releases the lower one first
      item_pred(FUNC_ALLOC, 8'h80);
      item_pred(FUNC_ALLOC, 8'h80);
      item_pred(FUNC_FREE,  8'h80);
      item_pred(FUNC_FREE,  8'h80);
      // oversized total saturates to 64 KiB; grant the whole memory at once
      csr_row(REG_TOTAL, SZ_ALL_ONES);
      csr_row(REG_PSIZE, 17'd65536);
      item_row (FUNC_ALLOC, 8'h01, ST_DONE,    16'd0,     7'd1, 17'd0);
      item_row (FUNC_ALLOC, 8'h02, ST_NOFIT,   16'd0,     7'd1, 17'd0);
      item_row (FUNC_FREE,  8'h01, ST_DONE,    16'd0,     7'd0, 17'd65536);
      // zero-size grants
      csr_row(REG_PSIZE, 17'd0);
      item_pred(FUNC_ALLOC, 8'hFE);
      item_pred(FUNC_ALLOC, 8'hFE);
      item_pred(FUNC_FREE,  8'hFE);
      item_pred(FUNC_FREE,  8'hFE);
      // smallest memory, grant larger than anything
      csr_row(REG_TOTAL, 17'd64);
      csr_row(REG_PSIZE, SZ_ALL_ONES);
      item_row (FUNC_ALLOC, 8'h33, ST_NOFIT,   16'd0,     7'd0, 17'd64);
      csr_row(REG_PSIZE, 17'd64);
      item_row (FUNC_ALLOC, 8'h33, ST_DONE,    16'd0,     7'd1, 17'd0);
      item_row (FUNC_FREE,  8'h33, ST_DONE,    16'd0,     7'd0, 17'd64);

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].is_csr) begin
            wait_idle();
            csr_write(directed_rows[r].reg_sel, directed_rows[r].value);
         end else begin
            send_request(directed_rows[r].func, directed_rows[r].owner,
                         directed_rows[r].typed, directed_rows[r].want);
         end
      end
      n_directed = n_items;

      // Random episodes. Each sets up the table, then runs a burst that mostly reuses a
      // small owner pool so frees find their segments. Fill episodes use a grant small
      // enough to push the table to its entry limit.
      n_random = 0;
      while (n_random < RANDOM_ITEMS) begin
         // sender gaps: moderate, then heavy, then back-to-back
         if (n_random < RANDOM_ITEMS/3)        sender_idle_pct = 31;
         else if (n_random < 2*RANDOM_ITEMS/3) sender_idle_pct = 77;
         else                                  sender_idle_pct = 0;

         fill = ($urandom_range(3) == 0);
         wait_idle();
         if (fill || $urandom_range(1) == 1) begin
            case ($urandom_range(4))
               0:       mem = 17'd64;
               1:       mem = 17'd65536;
               2:       mem = SZ_ALL_ONES;
               3:       mem = TOTAL_RST;
               default: mem = SZ_W'($urandom_range(64, 65536));
            endcase
            csr_write(REG_TOTAL, mem);
         end
         if (fill) begin
            psz = SZ_W'(memory_size / $urandom_range(64, 256));
         end else begin
            case ($urandom_range(7))
               0:       psz = 17'd0;
               1:       psz = 17'd1;
               2:       psz = 17'd65536;
               3:       psz = SZ_ALL_ONES;
               4:       psz = SZ_W'(memory_size / $urandom_range(1, 8));
               default: psz = SZ_W'($urandom_range(1, 2048));
            endcase
         end
         csr_write(REG_PSIZE, psz);

         pool_n = $urandom_range(1, 6);
         for (k = 0; k < pool_n; k++) pool[k] = OWNER_IN_W'($urandom_range(255));
         len = fill ? 100 : $urandom_range(20, 90);
         for (k = 0; k < len && n_random < RANDOM_ITEMS; k++) begin
            if (fill) alloc_pct = (k < 72) ? 100 : 50;
            else      alloc_pct = (k < len/2) ? 70 : 40;
            func  = ($urandom_range(99) < alloc_pct) ? FUNC_ALLOC : FUNC_FREE;
            // mostly pool owners; the rest is any id, usually a stray free
            owner = ($urandom_range(99) < 85) ? pool[$urandom_range(pool_n-1)]
                                              : OWNER_IN_W'($urandom_range(255));
            send_request(func, owner, 1'b0, '0);
            n_random++;
         end
      end

      wait_idle();
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("covered %0d requests (%0d directed) across %0d register writes",
               n_items, n_directed, n_csr);
      $display("outcomes: %0d done, %0d no fit, %0d table full, %0d owner missing",
               status_seen[ST_DONE], status_seen[ST_NOFIT],
               status_seen[ST_FULL], status_seen[ST_NOOWNER]);
      if (n_errors == 0)
         $display("first_fit_segment_allocator test passed");
      else
         $display("first_fit_segment_allocator test failed");
      $finish;
   end

endmodule
